// ----- rtl/bcrrs_pkg.sv -----
// Shared types and constants for the budgeted class round-robin selector.
// Used by bcrrs_ctrl, bcrrs_dp and budgeted_class_round_robin_select.
`default_nettype none

package bcrrs_pkg;

  localparam int MaxSlots = 16;
  localparam int IdxW     = $clog2(MaxSlots);
  localparam int CntW     = IdxW + 1;
  localparam int BudgetW  = 8;
  localparam int ClassW   = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTIVE_COUNT      = 3'd0,
    REG_CANDIDATE_CLASSES = 3'd1,
    REG_BUDGET_AMBIENT    = 3'd2,
    REG_BUDGET_SERVICE    = 3'd3,
    REG_BUDGET_SAFETY     = 3'd4
  } cfg_reg_t;

  typedef enum logic [ClassW-1:0] {
    CLS_AMBIENT    = 2'd0,
    CLS_SERVICE    = 2'd1,
    CLS_SAFETY     = 2'd2,
    CLS_UNBUDGETED = 2'd3
  } class_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic classify;
    logic grant;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/bcrrs_ctrl.sv -----
// Sequencer for the selector: capture, class pick with refill, grant.
// Depends on bcrrs_pkg for the command and status structs.
`default_nettype none

module bcrrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bcrrs_pkg::status_t status,
  output bcrrs_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CLASS = 3'b010,
    S_GRANT = 3'b100
  } state_t;

  state_t state, state_next;
  logic   take;

  always_comb begin
    take = 1'b0;
    case (state)
      S_IDLE:  take = 1'b1;
      S_GRANT: take = !status.out_busy;
      default: take = 1'b0;
    endcase
  end

  assign in_stall = !take;

  always_comb begin
    cmd          = '0;
    cmd.capture  = take && in_valid;
    cmd.classify = (state == S_CLASS);
    cmd.grant    = (state == S_GRANT) && !status.out_busy;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_CLASS;
      S_CLASS: state_next = S_GRANT;
      S_GRANT: begin
        if (!status.out_busy) state_next = in_valid ? S_CLASS : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  a_capture_then_class: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.classify)
    else $error("captured item did not move to class pick");

  a_class_then_grant: assert property (@(posedge clk) disable iff (rst)
    cmd.classify |=> state == S_GRANT)
    else $error("class pick not followed by grant state");

  a_hold_when_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_GRANT && status.out_busy |=> state == S_GRANT)
    else $error("grant left while result register full");

endmodule

`default_nettype wire

// ----- rtl/bcrrs_dp.sv -----
// Datapath: configuration registers, per-slot budget counters, class pick,
// refill, round-robin grant and the result register. Depends on bcrrs_pkg.
`default_nettype none

module bcrrs_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [bcrrs_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [bcrrs_pkg::CfgDataW-1:0]       cfg_data,
  input  logic [bcrrs_pkg::MaxSlots-1:0]       runnable_mask,
  input  logic signed [bcrrs_pkg::CntW-1:0]    previous_index,
  input  bcrrs_pkg::cmd_t                      cmd,
  output bcrrs_pkg::status_t                   status,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 found,
  output logic [bcrrs_pkg::IdxW-1:0]           selected_index,
  output logic                                 replenished
);

  localparam int Slots = bcrrs_pkg::MaxSlots;
  localparam int IdxW  = bcrrs_pkg::IdxW;
  localparam int CntW  = bcrrs_pkg::CntW;
  localparam int BW    = bcrrs_pkg::BudgetW;
  localparam int CW    = bcrrs_pkg::ClassW;

  // configuration
  logic [CntW-1:0]       active_count;
  logic [Slots*CW-1:0]   candidate_classes;
  logic [BW-1:0]         budget_ambient;
  logic [BW-1:0]         budget_service;
  logic [BW-1:0]         budget_safety;

  // captured item and per-item state
  logic [Slots-1:0]       mask_q;
  logic signed [CntW-1:0] prev_q;
  logic [BW-1:0]          rb [Slots];
  logic [CW-1:0]          top_q;
  logic                   top_ok;
  logic                   repl_q;

  logic [CW-1:0]    cls [Slots];
  logic [BW-1:0]    cb  [Slots];
  logic [Slots-1:0] in_rng, elig_old, elig_new, cand, hi, pick;
  logic             count_ok, prev_ok, req_ok;
  logic             old_ok, new_ok;
  logic [CW-1:0]    old_top, new_top;
  logic [CntW-1:0]  start;
  logic [IdxW-1:0]  grant_idx;
  logic             grant_found;

  function automatic logic [BW-1:0] class_budget(input logic [CW-1:0] c,
                                                 input logic [BW-1:0] b0,
                                                 input logic [BW-1:0] b1,
                                                 input logic [BW-1:0] b2);
    logic [BW-1:0] r;
    case (c)
      bcrrs_pkg::CLS_AMBIENT: r = b0;
      bcrrs_pkg::CLS_SERVICE: r = b1;
      bcrrs_pkg::CLS_SAFETY:  r = b2;
      default:                r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      cls[i]      = candidate_classes[CW*i +: CW];
      cb[i]       = class_budget(cls[i], budget_ambient, budget_service, budget_safety);
      in_rng[i]   = CntW'(i) < active_count;
      elig_new[i] = in_rng[i] && mask_q[i] && (cb[i] != '0);
      elig_old[i] = elig_new[i] && (rb[i] != '0);
    end
  end

  // Highest class among eligible slots; unbudgeted never qualifies.
  always_comb begin
    logic [3:0] has_old, has_new;
    has_old = '0;
    has_new = '0;
    for (int i = 0; i < Slots; i++) begin
      has_old[cls[i]] = has_old[cls[i]] | elig_old[i];
      has_new[cls[i]] = has_new[cls[i]] | elig_new[i];
    end
    old_ok  = |has_old[2:0];
    new_ok  = |has_new[2:0];
    old_top = has_old[bcrrs_pkg::CLS_SAFETY]  ? bcrrs_pkg::CLS_SAFETY  :
              has_old[bcrrs_pkg::CLS_SERVICE] ? bcrrs_pkg::CLS_SERVICE :
                                                bcrrs_pkg::CLS_AMBIENT;
    new_top = has_new[bcrrs_pkg::CLS_SAFETY]  ? bcrrs_pkg::CLS_SAFETY  :
              has_new[bcrrs_pkg::CLS_SERVICE] ? bcrrs_pkg::CLS_SERVICE :
                                                bcrrs_pkg::CLS_AMBIENT;
  end

  assign count_ok = (active_count != '0) && (active_count <= CntW'(Slots));
  assign prev_ok  = (prev_q == '1) ||
                    (!prev_q[CntW-1] && ({1'b0, prev_q[IdxW-1:0]} < active_count));
  assign req_ok   = count_ok && prev_ok;

  // Round robin: first candidate at or after prev+1, else wrap to the lowest.
  assign start = $unsigned(prev_q) + CntW'(1);

  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      cand[i] = top_ok && in_rng[i] && mask_q[i] && (rb[i] != '0) && (cls[i] == top_q);
    end
    hi          = cand & ({Slots{1'b1}} << start);
    pick        = (hi != '0) ? hi : cand;
    grant_found = (cand != '0);
    grant_idx   = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (pick[i]) grant_idx = IdxW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count      <= CntW'(16);
      candidate_classes <= '0;
      budget_ambient    <= BW'(1);
      budget_service    <= BW'(2);
      budget_safety     <= BW'(4);
    end else if (cfg_write) begin
      case (cfg_index)
        bcrrs_pkg::REG_ACTIVE_COUNT:      active_count      <= cfg_data[CntW-1:0];
        bcrrs_pkg::REG_CANDIDATE_CLASSES: candidate_classes <= cfg_data[Slots*CW-1:0];
        bcrrs_pkg::REG_BUDGET_AMBIENT:    budget_ambient    <= cfg_data[BW-1:0];
        bcrrs_pkg::REG_BUDGET_SERVICE:    budget_service    <= cfg_data[BW-1:0];
        bcrrs_pkg::REG_BUDGET_SAFETY:     budget_safety     <= cfg_data[BW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mask_q <= runnable_mask;
      prev_q <= previous_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_ok <= 1'b0;
      repl_q <= 1'b0;
      top_q  <= '0;
    end else if (cmd.classify) begin
      if (!req_ok) begin
        top_ok <= 1'b0;
        repl_q <= 1'b0;
      end else if (old_ok) begin
        top_ok <= 1'b1;
        top_q  <= old_top;
        repl_q <= 1'b0;
      end else begin
        top_ok <= new_ok;
        top_q  <= new_top;
        repl_q <= 1'b1;
      end
    end
  end

  // Budget counters: refill on a class pick that finds no eligible slot, decrement on grant.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Slots; i++) rb[i] <= '0;
    end else if (cmd.classify && req_ok && !old_ok) begin
      for (int i = 0; i < Slots; i++) begin
        if (in_rng[i]) rb[i] <= cb[i];
      end
    end else if (cmd.grant && grant_found) begin
      rb[grant_idx] <= rb[grant_idx] - BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.grant) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grant) begin
      found          <= grant_found;
      selected_index <= grant_found ? grant_idx : '0;
      replenished    <= repl_q;
    end
  end

  assign status.out_busy = out_valid && out_stall;

  a_grant_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.grant && grant_found |-> {1'b0, grant_idx} < active_count)
    else $error("grant outside active slots");

  a_grant_decrements: assert property (@(posedge clk) disable iff (rst)
    cmd.grant && grant_found |=> rb[$past(grant_idx)] == $past(rb[grant_idx]) - BW'(1))
    else $error("granted slot budget not decremented");

  a_refill_flags: assert property (@(posedge clk) disable iff (rst)
    cmd.classify && req_ok && !old_ok |=> repl_q)
    else $error("refill not flagged");

endmodule

`default_nettype wire

// ----- rtl/budgeted_class_round_robin_select.sv -----
// Budgeted class round-robin selector: one item in, one result out. An item
// goes through the two-step sequencer: a class pick (with a refill of the
// active slots when nothing is eligible), then the round-robin grant. The
// next item is captured during the grant step, which holds while the result
// register is full and stalled. The 16 budget counters start at zero, so the
// first item with a valid count and previous index refills them.
`default_nettype none

module budgeted_class_round_robin_select (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bcrrs_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [bcrrs_pkg::CfgDataW-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bcrrs_pkg::MaxSlots-1:0]      runnable_mask,
  input  logic signed [bcrrs_pkg::CntW-1:0]   previous_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                found,
  output logic [bcrrs_pkg::IdxW-1:0]          selected_index,
  output logic                                replenished
);

  bcrrs_pkg::cmd_t    cmd;
  bcrrs_pkg::status_t status;

  bcrrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bcrrs_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .runnable_mask  (runnable_mask),
    .previous_index (previous_index),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .found          (found),
    .selected_index (selected_index),
    .replenished    (replenished)
  );

endmodule

`default_nettype wire

// ----- bench/bcrrs_grant_check.sv -----
// Checker for the budgeted class round-robin selector: tracks register writes,
// predicts each grant from accepted items and compares accepted results.
// Depends on bcrrs_pkg.
module bcrrs_grant_check (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [bcrrs_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [bcrrs_pkg::CfgDataW-1:0]       cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [bcrrs_pkg::MaxSlots-1:0]       runnable_mask,
  input  logic signed [bcrrs_pkg::CntW-1:0]    previous_index,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic                                 found,
  input  logic [bcrrs_pkg::IdxW-1:0]           selected_index,
  input  logic                                 replenished,
  output int                                   errors,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                       found;
    logic [bcrrs_pkg::IdxW-1:0] slot;
    logic                       refilled;
  } grant_t;

  logic [4:0]                    slot_count;
  logic [31:0]                   slot_classes;
  logic [bcrrs_pkg::BudgetW-1:0] ambient_limit;
  logic [bcrrs_pkg::BudgetW-1:0] service_limit;
  logic [bcrrs_pkg::BudgetW-1:0] safety_limit;
  logic [bcrrs_pkg::BudgetW-1:0] credit [bcrrs_pkg::MaxSlots];
  grant_t                        grant_queue [$];

  function automatic bcrrs_pkg::class_t class_of(input int slot);
    return bcrrs_pkg::class_t'(slot_classes[2*slot +: 2]);
  endfunction

  function automatic logic [bcrrs_pkg::BudgetW-1:0] class_limit(
      input bcrrs_pkg::class_t c);
    case (c)
      bcrrs_pkg::CLS_AMBIENT: return ambient_limit;
      bcrrs_pkg::CLS_SERVICE: return service_limit;
      bcrrs_pkg::CLS_SAFETY:  return safety_limit;
      default:                return '0;
    endcase
  endfunction

  // Highest class with a runnable slot that still has credit, or -1.
  function automatic int best_class(input logic [bcrrs_pkg::MaxSlots-1:0] mask,
                                    input int cnt);
    int best;
    best = -1;
    for (int i = 0; i < cnt; i++) begin
      if (mask[i] && credit[i] != 0 && class_limit(class_of(i)) != 0 &&
          int'(class_of(i)) > best)
        best = int'(class_of(i));
    end
    return best;
  endfunction

  task automatic predict_grant(input logic [bcrrs_pkg::MaxSlots-1:0] mask,
                               input logic signed [bcrrs_pkg::CntW-1:0] prev_slot);
    grant_t g;
    int     top;
    int     cnt;
    int     p;
    int     idx;
    g   = '0;
    cnt = int'(slot_count);
    p   = int'(prev_slot);
    if (cnt >= 1 && cnt <= bcrrs_pkg::MaxSlots && p >= -1 && p < cnt) begin
      top = best_class(mask, cnt);
      if (top < 0) begin
        // refill only the active slots, then look again
        for (int i = 0; i < cnt; i++) credit[i] = class_limit(class_of(i));
        g.refilled = 1'b1;
        top = best_class(mask, cnt);
      end
      if (top >= 0) begin
        for (int s = 1; s <= cnt && !g.found; s++) begin
          idx = (p < 0) ? s - 1 : (p + s) % cnt;
          if (mask[idx] && credit[idx] != 0 && int'(class_of(idx)) == top) begin
            credit[idx] = credit[idx] - 1'b1;
            g.found = 1'b1;
            g.slot  = idx[bcrrs_pkg::IdxW-1:0];
          end
        end
      end
    end
    grant_queue.push_back(g);
  endtask

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      slot_count    = 5'd16;
      slot_classes  = '0;
      ambient_limit = 8'd1;
      service_limit = 8'd2;
      safety_limit  = 8'd4;
      for (int i = 0; i < bcrrs_pkg::MaxSlots; i++) credit[i] = '0;
      grant_queue.delete();
      pending <= 0;
    end else begin
      if (cfg_write) begin
        case (bcrrs_pkg::cfg_reg_t'(cfg_index))
          bcrrs_pkg::REG_ACTIVE_COUNT:      slot_count    = cfg_data[4:0];
          bcrrs_pkg::REG_CANDIDATE_CLASSES: slot_classes  = cfg_data;
          bcrrs_pkg::REG_BUDGET_AMBIENT:    ambient_limit = cfg_data[7:0];
          bcrrs_pkg::REG_BUDGET_SERVICE:    service_limit = cfg_data[7:0];
          bcrrs_pkg::REG_BUDGET_SAFETY:     safety_limit  = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_grant(runnable_mask, previous_index);
      if (out_valid && !out_stall) begin
        if (grant_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual found=%0b slot=%0d repl=%0b",
                   $time, found, selected_index, replenished);
          errors++;
        end else begin
          want = grant_queue.pop_front();
          check_field("found", 8'(want.found), 8'(found));
          check_field("selected_index", 8'(want.slot), 8'(selected_index));
          check_field("replenished", 8'(want.refilled), 8'(replenished));
        end
      end
      pending <= grant_queue.size();
    end
  end

endmodule

// ----- bench/tb_budgeted_class_round_robin_select.sv -----
// Top of the selector testbench: clock, reset, register writes, item stimulus
// and result stall pattern. Instantiates budgeted_class_round_robin_select and
// bcrrs_grant_check; depends on bcrrs_pkg.
module tb_budgeted_class_round_robin_select;
  timeunit 1ns;
  timeprecision 1ps;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_write = 1'b0;
  logic [bcrrs_pkg::CfgIdxW-1:0]      cfg_index = '0;
  logic [bcrrs_pkg::CfgDataW-1:0]     cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [bcrrs_pkg::MaxSlots-1:0]     runnable_mask = '0;
  logic signed [bcrrs_pkg::CntW-1:0]  previous_index = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               found;
  logic [bcrrs_pkg::IdxW-1:0]         selected_index;
  logic                               replenished;
  int                                 errors;
  int                                 pending;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   cur_count = 16;
  logic hold_kick = 1'b0;
  int   hold_left = 0;

  budgeted_class_round_robin_select DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .runnable_mask(runnable_mask), .previous_index(previous_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .selected_index(selected_index), .replenished(replenished)
  );

  bcrrs_grant_check checker_i (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .runnable_mask(runnable_mask), .previous_index(previous_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .selected_index(selected_index), .replenished(replenished),
    .errors(errors), .pending(pending)
  );

  always #1 clk = ~clk;

  // Result-side stall; a kick holds it off for a long stretch.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_kick) begin
      out_stall <= 1'b1;
      hold_left <= 400;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_item(input logic [bcrrs_pkg::MaxSlots-1:0] m, input int p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    runnable_mask  <= m;
    previous_index <= p[bcrrs_pkg::CntW-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input bcrrs_pkg::cfg_reg_t r,
                           input logic [bcrrs_pkg::CfgDataW-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic set_policy(input logic [4:0] cnt, input logic [31:0] classes,
                            input logic [7:0] amb, input logic [7:0] svc,
                            input logic [7:0] saf);
    wait_drained();
    write_reg(bcrrs_pkg::REG_ACTIVE_COUNT, {27'd0, cnt});
    write_reg(bcrrs_pkg::REG_CANDIDATE_CLASSES, classes);
    write_reg(bcrrs_pkg::REG_BUDGET_AMBIENT, {24'd0, amb});
    write_reg(bcrrs_pkg::REG_BUDGET_SERVICE, {24'd0, svc});
    write_reg(bcrrs_pkg::REG_BUDGET_SAFETY, {24'd0, saf});
    cfg_write <= 1'b0;
    cur_count = int'(cnt);
  endtask

  initial begin
    #2_000_000;
    $display("budgeted_class_round_robin_select verification failed");
    $finish;
  end

  initial begin
    logic [bcrrs_pkg::MaxSlots-1:0] m;
    int                             p;
    int                             n_items;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: all ambient, one grant per round.
    send_item(16'hffff, -1);
    send_item(16'hffff, 0);
    send_item(16'h0000, 3);
    send_item(16'hffff, 15);
    send_item(16'hffff, -2);
    send_item(16'hffff, -16);

    // Five slots: ambient, service, safety, unbudgeted, safety.
    set_policy(5'd5, 32'h0000_02e4, 8'd255, 8'd0, 8'd1);
    send_item(16'h001f, -1);
    send_item(16'h001f, 2);
    send_item(16'h001f, 4);
    send_item(16'h001f, 5);
    send_item(16'h000a, 0);
    send_item(16'hffe0, 1);
    send_item(16'h0010, 3);

    set_policy(5'd16, 32'hffff_ffff, 8'd255, 8'd255, 8'd255);
    send_item(16'hffff, -1);
    set_policy(5'd0, 32'h0000_0000, 8'd1, 8'd1, 8'd1);
    send_item(16'hffff, 0);
    set_policy(5'd31, 32'h0000_0000, 8'd1, 8'd1, 8'd1);
    send_item(16'hffff, -1);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_policy(5'd16, $urandom, 8'($urandom_range(1, 3)),
                      8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)));
        1: set_policy(5'd16, $urandom, 8'd255, 8'd255, 8'd255);
        2: set_policy(5'd1, $urandom, 8'($urandom_range(0, 3)),
                      8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
        3: set_policy(5'd2, $urandom, 8'd0, 8'd1, 8'd255);
        4: set_policy(5'($urandom_range(1, 16)), $urandom, 8'($urandom_range(0, 4)),
                      8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)));
        5: set_policy(5'($urandom_range(1, 16)), 32'haaaa_aaaa, 8'd0, 8'd0, 8'd1);
        6: set_policy(5'($urandom_range(3, 16)), 32'h0000_0000, 8'd2, 8'd0, 8'd0);
        7: set_policy(5'($urandom_range(1, 16)), $urandom, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        8: set_policy(5'd0, $urandom, 8'd1, 8'd1, 8'd1);
        default: set_policy(5'($urandom_range(17, 31)), $urandom, 8'd1, 8'd1, 8'd1);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      if (ph == 0) begin
        // long hold-off while the sender keeps offering items
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end
      n_items = (ph >= 8) ? 30 : 210;
      repeat (n_items) begin
        case ($urandom_range(0, 4))
          0: m = 16'($urandom);
          1: m = 16'($urandom & $urandom);
          2: m = 16'hffff;
          default: m = 16'($urandom | $urandom);
        endcase
        if ($urandom_range(0, 9) == 0 || cur_count < 1 || cur_count > bcrrs_pkg::MaxSlots)
          p = int'($urandom_range(0, 31)) - 16;
        else
          p = int'($urandom_range(0, cur_count)) - 1;
        send_item(m, p);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("budgeted_class_round_robin_select verification clean");
    else
      $display("budgeted_class_round_robin_select verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bcrrs_pkg.sv
rtl/bcrrs_ctrl.sv
rtl/bcrrs_dp.sv
rtl/budgeted_class_round_robin_select.sv
bench/bcrrs_grant_check.sv
bench/tb_budgeted_class_round_robin_select.sv
